/* rtl/qsm3_pkg.sv */
// Package for the median-of-three quicksort core.
// Holds defaults, LFSR constants and the controller/datapath command and status types.
// No dependencies.
package qsm3_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int STACK_DEPTH      = 64;
  localparam int SP_W             = $clog2(STACK_DEPTH) + 1;
  localparam int LFSR_W           = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam int MEDIAN_MIN_LEN   = 3;

  // element memory read source
  typedef enum logic [2:0] {
    RD_NONE,
    RD_IDX,
    RD_SX,
    RD_SY,
    RD_HI,
    RD_J
  } rd_sel_t;

  // element memory write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOAD,
    WR_SX_RD,
    WR_SY_A
  } wr_sel_t;

  // range stack push source
  typedef enum logic [1:0] {
    PUSH_NONE,
    PUSH_ALL,
    PUSH_LOW,
    PUSH_HIGH
  } push_sel_t;

  typedef struct packed {
    logic      load_en;
    logic      drop_set;
    logic      fin_clr;
    logic      sp_clr;
    push_sel_t push_sel;
    logic      pop;
    logic      rng_ld;
    logic      draw_start;
    logic      mod_step;
    logic      idx_ld;
    logic      k_clr;
    logic      cap_v;
    logic      med_sel;
    logic      part_sx;
    logic      fin_sx;
    logic      cap_a;
    rd_sel_t   rd_sel;
    wr_sel_t   wr_sel;
    logic      piv_ld;
    logic      part_init;
    logic      j_inc;
    logic      st_inc;
    logic      emit_init;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_lt2;
    logic sp_zero;
    logic rng_bad;
    logic len_ge3;
    logic mod_last;
    logic k_is2;
    logic j_eq_hi;
    logic le_piv;
    logic push1_ok;
    logic push2_ok;
    logic emit_last;
  } status_t;

endpackage

/* rtl/qsm3_if.sv */
// Channel interfaces for the median-of-three quicksort core.
// Valid/ready transfer of input elements and sorted results; no dependencies.
interface qsm3_in_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;
  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface qsm3_out_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sorted_value;
  logic                          final_res;
  logic                          overflow;
  modport source (output valid, sorted_value, final_res, overflow, input ready);
  modport sink   (input valid, sorted_value, final_res, overflow, output ready);
endinterface

/* rtl/quicksort_median_of_three_core.sv */
// Median-of-three quicksort core: loads one element per cycle, sorts on the last one.
// After the last element, each range is popped, its pivot loaded, each element compared,
// with a swap for each one at or below the pivot, then a final swap and pushes; a range of
// three or more first swaps in the median of three LFSR draws taken modulo its length.
// Results leave one at a time, held until taken; new sets load only after the final result.
// Reset (synchronous, rst_n low): empty store and stack, LFSR seeded to 0xACE1.
module quicksort_median_of_three_core
  import qsm3_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  qsm3_in_if.sink    in_ch,
  qsm3_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  qsm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .status    (status)
  );

  qsm3_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_value  (in_ch.value),
    .out_value (out_ch.sorted_value),
    .out_final (out_ch.final_res),
    .out_ovf   (out_ch.overflow)
  );

  // never load while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  // a last element starts the sort
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last) |=> !in_ch.ready)
    else $error("ready after last element");

  // final result returns the core to loading
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.final_res) |=> in_ch.ready)
    else $error("not ready after final result");

endmodule

/* rtl/qsm3_dpath.sv */
// Datapath of the quicksort core: element memory, range stack, LFSR, modulo unit,
// median select, partition pointers and output register. Uses qsm3_pkg.
module qsm3_dpath
  import qsm3_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic                          out_final,
  output logic                          out_ovf
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = AW + 1;
  localparam int SAW = SP_W - 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // storage
  logic signed [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];
  logic        [2*AW-1:0]        stk [STACK_DEPTH];

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           drop_r, drop_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;

  logic [AW-1:0] lo_r, hi_r, j_r, st_r, sx_r, sy_r;
  logic [CW-1:0] rem_r;
  logic [3:0]    bit_r;
  logic [1:0]    k_r;
  logic [AW-1:0] idx_r [3];
  logic signed [VALUE_WIDTH-1:0] v_r [3];
  logic signed [VALUE_WIDTH-1:0] piv_r, a_r, rdata_r;
  logic [2*AW-1:0] sdata_r;
  logic signed [VALUE_WIDTH-1:0] out_value_r;
  logic out_final_r, out_ovf_r;

  logic [CW-1:0] len;
  logic [CW-1:0] mod_t, mod_nxt;
  logic [AW-1:0] raddr, waddr, med_idx;
  logic signed [VALUE_WIDTH-1:0] wdata;
  logic we, re;
  logic [2*AW-1:0] push_data;
  logic push_we;
  logic le01, le_b2, le_s2;
  logic [AW-1:0] big_i, small_i;
  logic signed [VALUE_WIDTH-1:0] big_v, small_v;

  assign len = {1'b0, hi_r} - {1'b0, lo_r} + ONE_C;

  // control registers
  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    sp_nxt   = sp_r;
    lfsr_nxt = lfsr_r;
    if (cmd.load_en) cnt_nxt = cnt_r + ONE_C;
    if (cmd.drop_set) drop_nxt = 1'b1;
    if (cmd.fin_clr) begin
      cnt_nxt  = '0;
      drop_nxt = 1'b0;
    end
    if (cmd.sp_clr) sp_nxt = '0;
    else if (cmd.pop) sp_nxt = sp_r - SP_W'(1);
    else if (push_we) sp_nxt = sp_r + SP_W'(1);
    if (cmd.draw_start) begin
      lfsr_nxt = lfsr_r >> 1;
      if (lfsr_r[0]) lfsr_nxt = (lfsr_r >> 1) ^ LFSR_TAPS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
      sp_r   <= '0;
      lfsr_r <= LFSR_SEED;
    end else begin
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
      sp_r   <= sp_nxt;
      lfsr_r <= lfsr_nxt;
    end
  end

  // restoring remainder step, one LFSR bit per cycle, MSB first
  assign mod_t   = {rem_r[AW-1:0], lfsr_r[~bit_r]};
  assign mod_nxt = (mod_t >= len) ? (mod_t - len) : mod_t;

  // median of the three drawn values
  always_comb begin
    le01    = v_r[0] <= v_r[1];
    big_i   = le01 ? idx_r[1] : idx_r[0];
    small_i = le01 ? idx_r[0] : idx_r[1];
    big_v   = le01 ? v_r[1] : v_r[0];
    small_v = le01 ? v_r[0] : v_r[1];
    le_b2   = big_v <= v_r[2];
    le_s2   = small_v <= v_r[2];
    if (le_b2) med_idx = big_i;
    else if (le_s2) med_idx = idx_r[2];
    else med_idx = small_i;
  end

  // element memory port select
  always_comb begin
    re    = 1'b1;
    raddr = j_r;
    case (cmd.rd_sel)
      RD_NONE: re = 1'b0;
      RD_IDX:  raddr = idx_r[k_r];
      RD_SX:   raddr = sx_r;
      RD_SY:   raddr = sy_r;
      RD_HI:   raddr = hi_r;
      RD_J:    raddr = j_r;
      default: re = 1'b0;
    endcase
    we    = 1'b1;
    waddr = sx_r;
    wdata = rdata_r;
    case (cmd.wr_sel)
      WR_NONE:  we = 1'b0;
      WR_LOAD: begin
        waddr = cnt_r[AW-1:0];
        wdata = in_value;
      end
      WR_SX_RD: begin
        waddr = sx_r;
        wdata = rdata_r;
      end
      WR_SY_A: begin
        waddr = sy_r;
        wdata = a_r;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // range stack push select
  always_comb begin
    push_we   = 1'b0;
    push_data = {lo_r, hi_r};
    case (cmd.push_sel)
      PUSH_NONE: push_we = 1'b0;
      PUSH_ALL: begin
        push_we   = 1'b1;
        push_data = {{AW{1'b0}}, AW'(cnt_r - ONE_C)};
      end
      PUSH_LOW: begin
        push_we   = 1'b1;
        push_data = {lo_r, st_r - AW'(1)};
      end
      PUSH_HIGH: begin
        push_we   = 1'b1;
        push_data = {st_r + AW'(1), hi_r};
      end
      default: push_we = 1'b0;
    endcase
    if (sp_r >= SP_W'(STACK_DEPTH)) push_we = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push_we) stk[sp_r[SAW-1:0]] <= push_data;
    if (cmd.pop) sdata_r <= stk[SAW'(sp_r - SP_W'(1))];
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.rng_ld) begin
      lo_r <= sdata_r[2*AW-1:AW];
      hi_r <= sdata_r[AW-1:0];
    end
    if (cmd.draw_start) begin
      rem_r <= '0;
      bit_r <= '0;
    end else if (cmd.mod_step) begin
      rem_r <= mod_nxt;
      bit_r <= bit_r + 4'd1;
    end
    if (cmd.idx_ld) idx_r[k_r] <= lo_r + rem_r[AW-1:0];
    if (cmd.cap_v) v_r[k_r] <= rdata_r;
    if (cmd.k_clr) k_r <= '0;
    else if (cmd.idx_ld || cmd.cap_v) k_r <= k_r + 2'd1;
    if (cmd.med_sel) begin
      sx_r <= med_idx;
      sy_r <= hi_r;
    end else if (cmd.part_sx) begin
      sx_r <= j_r;
      sy_r <= st_r;
    end else if (cmd.fin_sx) begin
      sx_r <= hi_r;
      sy_r <= st_r;
    end
    if (cmd.cap_a) a_r <= rdata_r;
    if (cmd.piv_ld) piv_r <= rdata_r;
    if (cmd.part_init) begin
      j_r  <= lo_r;
      st_r <= lo_r;
    end else if (cmd.emit_init) begin
      j_r <= '0;
    end else begin
      if (cmd.j_inc) j_r <= j_r + AW'(1);
      if (cmd.st_inc) st_r <= st_r + AW'(1);
    end
    if (cmd.out_ld) begin
      out_value_r <= rdata_r;
      out_final_r <= status.emit_last;
      out_ovf_r   <= drop_r;
    end
  end

  // status toward the controller
  always_comb begin
    status.full      = cnt_r == MAX_C;
    status.cnt_lt2   = cnt_r < CW'(2);
    status.sp_zero   = sp_r == '0;
    status.rng_bad   = (lo_r >= hi_r) || ({1'b0, hi_r} >= MAX_C);
    status.len_ge3   = len >= CW'(MEDIAN_MIN_LEN);
    status.mod_last  = bit_r == 4'd15;
    status.k_is2     = k_r == 2'd2;
    status.j_eq_hi   = j_r == hi_r;
    status.le_piv    = rdata_r <= piv_r;
    status.push1_ok  = {1'b0, st_r} > ({1'b0, lo_r} + ONE_C);
    status.push2_ok  = {1'b0, hi_r} > ({1'b0, st_r} + ONE_C);
    status.emit_last = ({1'b0, j_r} + ONE_C) == cnt_r;
  end

  assign out_value = out_value_r;
  assign out_final = out_final_r;
  assign out_ovf   = out_ovf_r;

endmodule

/* rtl/qsm3_ctrl.sv */
// Controller of the quicksort core: one-hot sequencer for load, range pop,
// pivot draw, median, swap, partition, push and emit. Uses qsm3_pkg.
module qsm3_ctrl
  import qsm3_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [25:0] {
    ST_IDLE      = 26'd1 << 0,
    ST_SORT_INIT = 26'd1 << 1,
    ST_PUSH0     = 26'd1 << 2,
    ST_POP       = 26'd1 << 3,
    ST_RNG       = 26'd1 << 4,
    ST_RNG_CHK   = 26'd1 << 5,
    ST_DRAW      = 26'd1 << 6,
    ST_MOD       = 26'd1 << 7,
    ST_IDX       = 26'd1 << 8,
    ST_MRD       = 26'd1 << 9,
    ST_MCAP      = 26'd1 << 10,
    ST_MED       = 26'd1 << 11,
    ST_SW_RA     = 26'd1 << 12,
    ST_SW_RB     = 26'd1 << 13,
    ST_SW_WA     = 26'd1 << 14,
    ST_SW_WB     = 26'd1 << 15,
    ST_PIV_RD    = 26'd1 << 16,
    ST_PIV_CAP   = 26'd1 << 17,
    ST_PLOOP     = 26'd1 << 18,
    ST_PCMP      = 26'd1 << 19,
    ST_PUSH1     = 26'd1 << 20,
    ST_PUSH2     = 26'd1 << 21,
    ST_EMIT_INIT = 26'd1 << 22,
    ST_ERD       = 26'd1 << 23,
    ST_ECAP      = 26'd1 << 24,
    ST_EHOLD     = 26'd1 << 25
  } state_t;

  // where a swap returns to
  typedef enum logic [1:0] {
    RET_MED,
    RET_PART,
    RET_FIN
  } ret_t;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = state_r == ST_EHOLD;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = '0;
    cmd.push_sel = PUSH_NONE;
    cmd.rd_sel   = RD_NONE;
    cmd.wr_sel   = WR_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.full) cmd.drop_set = 1'b1;
          else begin
            cmd.load_en = 1'b1;
            cmd.wr_sel  = WR_LOAD;
          end
          if (in_last) state_nxt = ST_SORT_INIT;
        end
      end
      ST_SORT_INIT: begin
        cmd.sp_clr = 1'b1;
        state_nxt  = status.cnt_lt2 ? ST_EMIT_INIT : ST_PUSH0;
      end
      ST_PUSH0: begin
        cmd.push_sel = PUSH_ALL;
        state_nxt    = ST_POP;
      end
      ST_POP: begin
        if (status.sp_zero) state_nxt = ST_EMIT_INIT;
        else begin
          cmd.pop   = 1'b1;
          state_nxt = ST_RNG;
        end
      end
      ST_RNG: begin
        cmd.rng_ld = 1'b1;
        state_nxt  = ST_RNG_CHK;
      end
      ST_RNG_CHK: begin
        if (status.rng_bad) state_nxt = ST_POP;
        else if (status.len_ge3) begin
          cmd.k_clr = 1'b1;
          state_nxt = ST_DRAW;
        end else state_nxt = ST_PIV_RD;
      end
      // step the LFSR and reduce it modulo the range length
      ST_DRAW: begin
        cmd.draw_start = 1'b1;
        state_nxt      = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) state_nxt = ST_IDX;
      end
      ST_IDX: begin
        if (status.k_is2) begin
          cmd.idx_ld = 1'b1;
          cmd.k_clr  = 1'b1;
          state_nxt  = ST_MRD;
        end else begin
          cmd.idx_ld = 1'b1;
          state_nxt  = ST_DRAW;
        end
      end
      ST_MRD: begin
        cmd.rd_sel = RD_IDX;
        state_nxt  = ST_MCAP;
      end
      ST_MCAP: begin
        cmd.cap_v = 1'b1;
        state_nxt = status.k_is2 ? ST_MED : ST_MRD;
      end
      ST_MED: begin
        cmd.med_sel = 1'b1;
        ret_nxt     = RET_MED;
        state_nxt   = ST_SW_RA;
      end
      // swap two entries: read both, then write each with the other's value
      ST_SW_RA: begin
        cmd.rd_sel = RD_SX;
        state_nxt  = ST_SW_RB;
      end
      ST_SW_RB: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_sel = RD_SY;
        state_nxt  = ST_SW_WA;
      end
      ST_SW_WA: begin
        cmd.wr_sel = WR_SX_RD;
        state_nxt  = ST_SW_WB;
      end
      ST_SW_WB: begin
        cmd.wr_sel = WR_SY_A;
        case (ret_r)
          RET_MED:  state_nxt = ST_PIV_RD;
          RET_PART: begin
            cmd.j_inc  = 1'b1;
            cmd.st_inc = 1'b1;
            state_nxt  = ST_PLOOP;
          end
          RET_FIN:  state_nxt = ST_PUSH1;
          default:  state_nxt = ST_PUSH1;
        endcase
      end
      // Lomuto partition
      ST_PIV_RD: begin
        cmd.rd_sel    = RD_HI;
        cmd.part_init = 1'b1;
        state_nxt     = ST_PIV_CAP;
      end
      ST_PIV_CAP: begin
        cmd.piv_ld = 1'b1;
        state_nxt  = ST_PLOOP;
      end
      ST_PLOOP: begin
        if (status.j_eq_hi) begin
          cmd.fin_sx = 1'b1;
          ret_nxt    = RET_FIN;
          state_nxt  = ST_SW_RA;
        end else begin
          cmd.rd_sel = RD_J;
          state_nxt  = ST_PCMP;
        end
      end
      ST_PCMP: begin
        if (status.le_piv) begin
          cmd.part_sx = 1'b1;
          ret_nxt     = RET_PART;
          state_nxt   = ST_SW_RA;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = ST_PLOOP;
        end
      end
      ST_PUSH1: begin
        if (status.push1_ok) cmd.push_sel = PUSH_LOW;
        state_nxt = ST_PUSH2;
      end
      ST_PUSH2: begin
        if (status.push2_ok) cmd.push_sel = PUSH_HIGH;
        state_nxt = ST_POP;
      end
      // stream the sorted store out
      ST_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        state_nxt     = ST_ERD;
      end
      ST_ERD: begin
        cmd.rd_sel = RD_J;
        state_nxt  = ST_ECAP;
      end
      ST_ECAP: begin
        cmd.out_ld = 1'b1;
        state_nxt  = ST_EHOLD;
      end
      ST_EHOLD: begin
        if (out_ready) begin
          if (status.emit_last) begin
            cmd.fin_clr = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = ST_ERD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= RET_MED;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule
